/* src/fvk_pkg.sv */
// shared constants, widths and helpers for the scara forward velocity block
`timescale 1ns / 1ps
package fvk_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int RATE_BITS  = 16;

	localparam int PHASE_W = 32;
	localparam int FRAC_W  = 30;
	localparam int X_W     = FRAC_W + 1;
	localparam int TRIG_W  = 32;
	localparam int LEN_W   = 16;
	localparam int DB_W    = 15;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;
	localparam int LS_W    = 32;
	localparam int LPROD_W = LEN_W + 1 + TRIG_W;
	localparam int PAIR_W  = LS_W + 1;
	localparam int VPROD_W = PAIR_W + RATE_BITS;
	localparam int VSUM_W  = VPROD_W + 1;
	localparam int VRND_W  = VSUM_W - FRAC_W;
	localparam int WZ_IN_W = RATE_BITS + 1;

	localparam int VX_W = 18;
	localparam int VZ_W = 16;
	localparam int WZ_W = 17;

	localparam logic [X_W-1:0] Q30_ONE = X_W'(1) << FRAC_W;
	localparam logic [TRIG_W-1:0] POLY_A1 = 32'd1686629713;
	localparam logic [TRIG_W-1:0] POLY_A3 = 32'd693598668;
	localparam logic [TRIG_W-1:0] POLY_A5 = 32'd85569306;
	localparam logic [TRIG_W-1:0] POLY_A7 = 32'd5026995;
	localparam logic [TRIG_W-1:0] POLY_A9 = 32'd172272;

	localparam logic [IDX_W-1:0] REG_LINK_ONE = 2'd0;
	localparam logic [IDX_W-1:0] REG_LINK_TWO = 2'd1;
	localparam logic [IDX_W-1:0] REG_DEADBAND = 2'd2;

	localparam logic [LEN_W-1:0] LINK_RESET = 16'd13107;
	localparam logic [DB_W-1:0]  DB_RESET   = 15'd1;

	// clamp to a signed field of the given width, then zero small magnitudes
	function automatic logic signed [63:0] sat_db(input logic signed [63:0] v,
			input int bits, input logic [DB_W-1:0] db);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		logic signed [63:0] r;
		logic signed [63:0] mag;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		r = v;
		if (r > hi) begin
			r = hi;
		end
		if (r < lo) begin
			r = lo;
		end
		mag = (r < 0) ? -r : r;
		if (mag <= $signed({49'd0, db})) begin
			r = '0;
		end
		return r;
	endfunction
endpackage

/* src/scara_forward_velocity_kinematics.sv */
// top level: scara tip velocity from joint angles and rates, 13-stage pipeline
// Usage:
// - input channel in_valid/in_ready carries angle_one, angle_two, rate_one,
//   rate_two, rate_three; one item is taken per cycle while in_ready is high
// - output channel out_valid/out_ready carries tip_vx, tip_vy, tip_vz, tip_wz
// - throughput is one item per cycle while out_ready does not stall, set by
//   the 13-stage multiply pipeline (four sine units, link scaling and rate
//   products)
// - config port cfg_valid/cfg_ready/cfg_index/cfg_data writes link_one_length,
//   link_two_length, deadband; always ready, index 3 is ignored
// - write config only while no item is in flight
// - reset clears all valid bits and loads default lengths and deadband
// - when out_ready is low with a result waiting the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated
`timescale 1ns / 1ps
module scara_forward_velocity_kinematics (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [fvk_pkg::ANGLE_BITS-1:0] angle_one,
	input  logic signed [fvk_pkg::ANGLE_BITS-1:0] angle_two,
	input  logic signed [fvk_pkg::RATE_BITS-1:0]  rate_one,
	input  logic signed [fvk_pkg::RATE_BITS-1:0]  rate_two,
	input  logic signed [fvk_pkg::RATE_BITS-1:0]  rate_three,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fvk_pkg::VX_W-1:0]      tip_vx,
	output logic signed [fvk_pkg::VX_W-1:0]      tip_vy,
	output logic signed [fvk_pkg::VZ_W-1:0]      tip_vz,
	output logic signed [fvk_pkg::WZ_W-1:0]      tip_wz,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fvk_pkg::IDX_W-1:0]            cfg_index,
	input  logic [fvk_pkg::CFG_W-1:0]            cfg_data
);
	import fvk_pkg::*;

	localparam int LAST = 13;
	localparam int RND_L = 16;

	logic [LEN_W-1:0] link_one_q, link_two_q;
	logic [DB_W-1:0]  deadband_q;
	logic             en;
	logic [LAST:1]    v_s;

	// rate carry lines, index is the stage
	logic signed [RATE_BITS-1:0] dq1_s [1:10];
	logic signed [RATE_BITS-1:0] dq2_s [1:10];
	logic signed [RATE_BITS-1:0] dq3_s [1:12];
	logic signed [WZ_IN_W-1:0]   wz_s  [1:12];

	logic [X_W-1:0] x_s1 [4];
	logic [1:0]     quad_s1 [4];
	logic signed [TRIG_W-1:0]  sin_s7 [4];
	logic signed [LPROD_W-1:0] prod_s8 [4];
	logic signed [LS_W-1:0]    ls_s9 [4];
	logic signed [PAIR_W-1:0]  sx_s10, cy_s10, ls12_s10, lc12_s10;
	logic signed [VPROD_W-1:0] pax_s11, pbx_s11, pay_s11, pby_s11;
	logic signed [VRND_W-1:0]  vx_s12, vy_s12;
	logic signed [VX_W-1:0]    vx_s13, vy_s13;
	logic signed [VZ_W-1:0]    vz_s13;
	logic signed [WZ_W-1:0]    wz_s13;

	logic [PHASE_W-1:0] ph [4];
	logic [PHASE_W-1:0] p1, p2, p12;
	logic signed [LS_W-1:0]   ls_rnd [4];
	logic signed [VSUM_W-1:0] vxs, vys, vxb, vyb;

	assign en        = !v_s[LAST] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s[LAST];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_one_q <= LINK_RESET;
			link_two_q <= LINK_RESET;
			deadband_q <= DB_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LINK_ONE: link_one_q <= cfg_data[LEN_W-1:0];
				REG_LINK_TWO: link_two_q <= cfg_data[LEN_W-1:0];
				REG_DEADBAND: deadband_q <= cfg_data[DB_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[LAST-1:1], in_valid};
		end
	end

	// phases: sin q1, cos q1, sin q12, cos q12
	always_comb begin
		p1 = {angle_one, {(PHASE_W-ANGLE_BITS){1'b0}}};
		p2 = {angle_two, {(PHASE_W-ANGLE_BITS){1'b0}}};
		p12 = p1 + p2;
		ph[0] = p1;
		ph[1] = p1 + (PHASE_W'(1) << FRAC_W);
		ph[2] = p12;
		ph[3] = p12 + (PHASE_W'(1) << FRAC_W);
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ls_rnd[i] = LS_W'((prod_s8[i] + LPROD_W'((1 << (RND_L - 1)) -
				(prod_s8[i] < 0 ? 1 : 0))) >>> RND_L);
		end
		vxs = -(VSUM_W'(pax_s11) + VSUM_W'(pbx_s11));
		vys = VSUM_W'(pay_s11) + VSUM_W'(pby_s11);
		vxb = vxs + VSUM_W'((1 << (FRAC_W - 1)) - (vxs < 0 ? 1 : 0));
		vyb = vys + VSUM_W'((1 << (FRAC_W - 1)) - (vys < 0 ? 1 : 0));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				quad_s1[i] <= ph[i][PHASE_W-1:FRAC_W];
				x_s1[i] <= ph[i][FRAC_W] ? Q30_ONE - X_W'(ph[i][FRAC_W-1:0])
					: X_W'(ph[i][FRAC_W-1:0]);
				prod_s8[i] <= $signed({1'b0, (i < 2) ? link_one_q : link_two_q})
					* sin_s7[i];
				ls_s9[i] <= ls_rnd[i];
			end
			dq1_s[1] <= rate_one;
			dq2_s[1] <= rate_two;
			dq3_s[1] <= rate_three;
			wz_s[1]  <= WZ_IN_W'(rate_one) + WZ_IN_W'(rate_two);
			for (int k = 2; k <= 10; k++) begin
				dq1_s[k] <= dq1_s[k-1];
				dq2_s[k] <= dq2_s[k-1];
			end
			for (int k = 2; k <= 12; k++) begin
				dq3_s[k] <= dq3_s[k-1];
				wz_s[k]  <= wz_s[k-1];
			end
			sx_s10   <= PAIR_W'(ls_s9[0]) + PAIR_W'(ls_s9[2]);
			cy_s10   <= PAIR_W'(ls_s9[1]) + PAIR_W'(ls_s9[3]);
			ls12_s10 <= PAIR_W'(ls_s9[2]);
			lc12_s10 <= PAIR_W'(ls_s9[3]);
			pax_s11 <= VPROD_W'(sx_s10) * VPROD_W'(dq1_s[10]);
			pbx_s11 <= VPROD_W'(ls12_s10) * VPROD_W'(dq2_s[10]);
			pay_s11 <= VPROD_W'(cy_s10) * VPROD_W'(dq1_s[10]);
			pby_s11 <= VPROD_W'(lc12_s10) * VPROD_W'(dq2_s[10]);
			vx_s12 <= VRND_W'(vxb >>> FRAC_W);
			vy_s12 <= VRND_W'(vyb >>> FRAC_W);
			vx_s13 <= VX_W'(sat_db(64'(vx_s12), VX_W, deadband_q));
			vy_s13 <= VX_W'(sat_db(64'(vy_s12), VX_W, deadband_q));
			vz_s13 <= VZ_W'(sat_db(64'(dq3_s[12]), VZ_W, deadband_q));
			wz_s13 <= WZ_W'(sat_db(64'(wz_s[12]), WZ_W, deadband_q));
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_sin
		fvk_sin u_sin (
			.clk     (clk),
			.en      (en),
			.x_in    (x_s1[g]),
			.quad_in (quad_s1[g]),
			.sin_out (sin_s7[g])
		);
	end

	assign tip_vx = vx_s13;
	assign tip_vy = vy_s13;
	assign tip_vz = vz_s13;
	assign tip_wz = wz_s13;

	logic signed [VX_W:0] vx_ext;
	logic signed [WZ_W:0] wz_ext;
	logic [VX_W:0]        vx_abs;
	logic [WZ_W:0]        wz_abs;

	assign vx_ext = tip_vx;
	assign wz_ext = tip_wz;
	assign vx_abs = (vx_ext < 0) ? $unsigned(-vx_ext) : $unsigned(vx_ext);
	assign wz_abs = (wz_ext < 0) ? $unsigned(-wz_ext) : $unsigned(wz_ext);

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[LAST-1] && en |=> out_valid)
		else $error("item lost between last two stages");

	a_vx_db: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tip_vx == 0) || (vx_abs > (VX_W+1)'(deadband_q)))
		else $error("tip_vx inside deadband");

	a_wz_db: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tip_wz == 0) || (wz_abs > (WZ_W+1)'(deadband_q)))
		else $error("tip_wz inside deadband");
endmodule

/* src/fvk_sin.sv */
// pipelined quarter-wave sine polynomial, six stages
`timescale 1ns / 1ps
module fvk_sin (
	input  logic                              clk,
	input  logic                              en,
	input  logic [fvk_pkg::X_W-1:0]           x_in,
	input  logic [1:0]                        quad_in,
	output logic signed [fvk_pkg::TRIG_W-1:0] sin_out
);
	import fvk_pkg::*;

	logic [X_W-1:0]    x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [1:0]        quad_s2, quad_s3, quad_s4, quad_s5, quad_s6;
	logic [X_W-1:0]    x2_s2, x2_s3, x2_s4, x2_s5;
	logic [TRIG_W-1:0] t_s3, t_s4, t_s5, t_s6;
	logic signed [TRIG_W-1:0] sin_s7;

	logic [2*X_W-1:0]      sq;
	logic [X_W+TRIG_W-1:0] h3, h4, h5, h6, mp;
	logic [X_W-1:0]        mc;
	logic [TRIG_W-1:0]     mag;

	assign sq = x_in * x_in;
	assign h3 = x2_s2 * POLY_A9;
	assign h4 = x2_s3 * t_s3;
	assign h5 = x2_s4 * t_s4;
	assign h6 = x2_s5 * t_s5;
	assign mp = x_s6 * t_s6;

	always_comb begin
		if (mp[X_W+TRIG_W-1:FRAC_W] > (X_W+TRIG_W-FRAC_W)'(Q30_ONE)) begin
			mc = Q30_ONE;
		end else begin
			mc = mp[FRAC_W+X_W-1:FRAC_W];
		end
		mag = {1'b0, mc};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s2   <= sq[FRAC_W+X_W-1:FRAC_W];
			x_s2    <= x_in;
			quad_s2 <= quad_in;
			t_s3    <= POLY_A7 - h3[FRAC_W+TRIG_W-1:FRAC_W];
			x2_s3   <= x2_s2;
			x_s3    <= x_s2;
			quad_s3 <= quad_s2;
			t_s4    <= POLY_A5 - h4[FRAC_W+TRIG_W-1:FRAC_W];
			x2_s4   <= x2_s3;
			x_s4    <= x_s3;
			quad_s4 <= quad_s3;
			t_s5    <= POLY_A3 - h5[FRAC_W+TRIG_W-1:FRAC_W];
			x2_s5   <= x2_s4;
			x_s5    <= x_s4;
			quad_s5 <= quad_s4;
			t_s6    <= POLY_A1 - h6[FRAC_W+TRIG_W-1:FRAC_W];
			x_s6    <= x_s5;
			quad_s6 <= quad_s5;
			sin_s7  <= quad_s6[1] ? -$signed(mag) : $signed(mag);
		end
	end

	assign sin_out = sin_s7;
endmodule
